>>> rtl/cut_inequality_separation_macros.svh
`ifndef CUT_INEQUALITY_SEPARATION_MACROS_SVH
`define CUT_INEQUALITY_SEPARATION_MACROS_SVH

// immediate implication check, same cycle
`define CIS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication check, next cycle
`define CIS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cis_pkg.sv
package cis_pkg;

   localparam int STORE_DIM = 5;
   localparam int FRAC_BITS = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GEN,
      ST_ACC,
      ST_SCORE,
      ST_CHECK,
      ST_EMIT,
      ST_RESULT
   } state_type;

   localparam logic [1:0] STAT_FOUND    = 2'd0;
   localparam logic [1:0] STAT_UNSUP    = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;

   localparam logic [1:0] T_ZERO = 2'b00;
   localparam logic [1:0] T_POS  = 2'b01;
   localparam logic [1:0] T_NEG  = 2'b11;

   typedef logic [STORE_DIM-1:0][1:0] vec_type;

   typedef struct packed {
      logic clear_best;
      logic clear_score;
      logic clear_acc;
      logic add_en;
      logic sub;
      logic score_en;
      logic offset5;
   } eval_ctl_type;

   typedef struct packed {
      logic lt_unit2;
      logic gt_unit2;
      logic lt_2unit2;
   } eval_flag_type;

   localparam logic [2:0] PAIR_D1 [10] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1,
                                          3'd2, 3'd2, 3'd3};
   localparam logic [2:0] PAIR_D2 [10] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4,
                                          3'd3, 3'd4, 3'd4};

   function automatic vec_type gen_t(input logic [2:0] n, input logic [5:0] cand,
                                     input logic phase2);
      vec_type t;
      logic [1:0] x;
      logic [2:0] d;
      logic [2:0] d2;
      t = '0;
      x = T_ZERO;
      d = 3'd0;
      d2 = 3'd0;
      if (phase2) begin
         for (int k = 0; k < 4; k++) t[k] = cand[k] ? T_POS : T_NEG;
         t[4] = T_POS;
      end else begin
         t[0] = cand[0] ? T_POS : T_NEG;
         t[1] = cand[1] ? T_POS : T_NEG;
         t[2] = T_POS;
         if (n == 3'd4) begin
            d = {1'b0, cand[3:2]};
            x = t[d];
            t[d] = t[3];
            t[3] = x;
         end else if (n == 3'd5) begin
            d = (cand[5:2] < 4'd10) ? PAIR_D1[cand[5:2]] : 3'd0;
            d2 = (cand[5:2] < 4'd10) ? PAIR_D2[cand[5:2]] : 3'd4;
            x = t[d];
            t[d] = t[3];
            t[3] = x;
            x = t[d2];
            t[d2] = t[4];
            t[4] = x;
         end
      end
      return t;
   endfunction

endpackage

>>> rtl/cis_matrix.sv
module cis_matrix #(
   parameter int MAX_DIM = 5,
   parameter int VALUE_WIDTH = 18,
   parameter int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [IW-1:0]                 wr_row,
   input  logic [IW-1:0]                 wr_col,
   input  logic signed [VALUE_WIDTH-1:0] wr_value,
   input  logic [IW-1:0]                 rd_row,
   input  logic [IW-1:0]                 rd_col,
   output logic signed [VALUE_WIDTH-1:0] rd_value
);
   logic signed [VALUE_WIDTH-1:0] mem_ff [MAX_DIM][MAX_DIM];
   logic signed [VALUE_WIDTH-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row][wr_col] <= wr_value;
      end
      rd_value_ff <= mem_ff[rd_row][rd_col];
   end

   assign rd_value = rd_value_ff;
endmodule

>>> rtl/cis_eval.sv
`include "cut_inequality_separation_macros.svh"

module cis_eval #(
   parameter int VALUE_WIDTH = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cis_pkg::eval_ctl_type         ctl,
   input  logic signed [VALUE_WIDTH-1:0] term,
   input  cis_pkg::vec_type              t_vec,
   output cis_pkg::vec_type              best_vec,
   output cis_pkg::eval_flag_type        flags
);
   import cis_pkg::*;

   localparam int SW = ((VALUE_WIDTH > FRAC_BITS + 2) ? VALUE_WIDTH : FRAC_BITS + 2) + 6;
   localparam int FRAC = FRAC_BITS;
   localparam logic signed [SW-1:0] ONE = SW'(1) << FRAC;
   localparam logic signed [SW-1:0] UNIT2 = ONE <<< 1;

   logic signed [SW-1:0] acc_ff, acc_in;
   logic signed [SW-1:0] best_ff, best_in;
   vec_type              pat_ff, pat_in;
   logic signed [SW-1:0] term_x;
   logic signed [SW-1:0] s2;
   logic                 better;

   assign term_x = SW'(term);
   assign s2 = acc_ff - (ctl.offset5 ? (ONE * SW'(5)) : (ONE * SW'(3)));
   assign better = s2 < best_ff;

   always_comb begin
      acc_in = acc_ff;
      best_in = best_ff;
      pat_in = pat_ff;
      if (ctl.clear_acc) begin
         acc_in = '0;
      end else if (ctl.add_en) begin
         acc_in = ctl.sub ? (acc_ff - term_x) : (acc_ff + term_x);
      end
      if (ctl.clear_best) begin
         best_in = '0;
         pat_in = {STORE_DIM{T_POS}};
      end else if (ctl.clear_score) begin
         best_in = '0;
      end else if (ctl.score_en && better) begin
         best_in = s2;
         pat_in = t_vec;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (reset) begin
         best_ff <= '0;
         pat_ff <= {STORE_DIM{T_POS}};
      end else begin
         best_ff <= best_in;
         pat_ff <= pat_in;
      end
   end

   assign best_vec = pat_ff;
   assign flags.lt_unit2 = best_ff < -UNIT2;
   assign flags.gt_unit2 = best_ff > -UNIT2;
   assign flags.lt_2unit2 = best_ff < -(UNIT2 <<< 1);

   `CIS_ASSERT_NEXT(a_best_update, clock, reset, ctl.score_en && better && !ctl.clear_best && !ctl.clear_score, best_ff == $past(s2), "best score not updated")
   `CIS_ASSERT_NEXT(a_best_clear, clock, reset, ctl.clear_best || ctl.clear_score, best_ff == '0, "best score not cleared")
   `CIS_ASSERT_NOW(a_best_nonpos, clock, reset, !best_ff[SW-1], best_ff == '0, "best score positive")
endmodule

>>> rtl/cut_inequality_separation.sv
// Search: after the request marked tlast, each candidate vector is generated, then
// accumulated in one shared adder pass over the matrix, then scored and compared;
// results then leave through the output register, held while rsp_tready is low.
// Throughput: one request per cycle while loading; not ready during the search and
// until the last result is loaded into the output register.
// Reset: synchronous, active high; clears control and best score, not the matrix.
module cut_inequality_separation #(
   parameter int MAX_DIM = 5,
   parameter int VALUE_WIDTH = 18
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // dim[2:0], row[5:3], col[8:6], value[VALUE_WIDTH+8:9], zero fill
   input  logic [((VALUE_WIDTH+9+7)/8)*8-1:0] req_tdata,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // coef_index[3:0], coef_value[5:4], zero fill
   output logic [7:0] rsp_tdata,
   // status[1:0]
   output logic [1:0] rsp_tuser,
   output logic rsp_tlast
);
   import cis_pkg::*;

   localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   state_type     state_ff, state_in;
   logic [2:0]    n_ff, n_in;
   logic [5:0]    cand_ff, cand_in;
   logic          phase_ff, phase_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic          head_ff, head_in;
   vec_type       t_ff, t_in;
   logic [1:0]    stat_ff, stat_in;
   logic          ovalid_ff, ovalid_in;
   logic [7:0]    odata_ff, odata_in;
   logic [1:0]    ouser_ff, ouser_in;
   logic          olast_ff, olast_in;

   eval_ctl_type  ctl;
   eval_flag_type flags;
   vec_type       best_vec;
   logic signed [VALUE_WIDTH-1:0] rd_value;

   logic [2:0] f_dim, f_row, f_col;
   logic       accept, wr_ok, out_free, last_term;
   logic [5:0] cand_last;
   logic [1:0] ti, tj, bi, bj;
   logic [1:0] prod;
   logic [IW-1:0] nm1;

   assign f_dim = req_tdata[2:0];
   assign f_row = req_tdata[5:3];
   assign f_col = req_tdata[8:6];
   assign accept = req_tvalid && req_tready;
   assign wr_ok = accept && (32'(f_row) < MAX_DIM) && (32'(f_col) < MAX_DIM);
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free = !ovalid_ff || rsp_tready;
   assign nm1 = IW'(n_ff - 3'd1);
   assign last_term = (i_ff == nm1) && (j_ff == nm1);

   // read address is the next-state index, so the registered read data matches the current indices
   cis_matrix #(.MAX_DIM(MAX_DIM), .VALUE_WIDTH(VALUE_WIDTH)) u_matrix (
      .clock(clock),
      .wr_en(wr_ok),
      .wr_row(f_row[IW-1:0]),
      .wr_col(f_col[IW-1:0]),
      .wr_value(req_tdata[VALUE_WIDTH+8:9]),
      .rd_row(i_in),
      .rd_col(j_in),
      .rd_value(rd_value)
   );

   cis_eval #(.VALUE_WIDTH(VALUE_WIDTH)) u_eval (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .term(rd_value),
      .t_vec(t_ff),
      .best_vec(best_vec),
      .flags(flags)
   );

   always_comb begin
      ti = t_ff[i_ff];
      tj = t_ff[j_ff];
      bi = best_vec[i_ff];
      bj = best_vec[j_ff];
      if (bi == T_ZERO || bj == T_ZERO) prod = T_ZERO;
      else prod = (bi == bj) ? T_POS : T_NEG;
      if (phase_ff) cand_last = 6'd15;
      else if (n_ff == 3'd3) cand_last = 6'd3;
      else if (n_ff == 3'd4) cand_last = 6'd15;
      else cand_last = 6'd39;
   end

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      cand_in = cand_ff;
      phase_in = phase_ff;
      i_in = i_ff;
      j_in = j_ff;
      head_in = head_ff;
      t_in = t_ff;
      stat_in = stat_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in = odata_ff;
      ouser_in = ouser_ff;
      olast_in = olast_ff;
      ctl = '0;
      ctl.offset5 = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tlast) begin
               if (f_dim < 3'd3 || 32'(f_dim) > MAX_DIM) begin
                  stat_in = STAT_UNSUP;
                  state_in = ST_RESULT;
               end else begin
                  n_in = f_dim;
                  cand_in = '0;
                  phase_in = 1'b0;
                  ctl.clear_best = 1'b1;
                  state_in = ST_GEN;
               end
            end
         end
         ST_GEN: begin
            t_in = gen_t(n_ff, cand_ff, phase_ff);
            i_in = '0;
            j_in = '0;
            ctl.clear_acc = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            ctl.add_en = (ti != T_ZERO) && (tj != T_ZERO);
            ctl.sub = (ti != tj);
            if (last_term) begin
               state_in = ST_SCORE;
            end else if (j_ff == nm1) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_SCORE: begin
            ctl.score_en = 1'b1;
            cand_in = cand_ff + 6'd1;
            state_in = (cand_ff == cand_last) ? ST_CHECK : ST_GEN;
         end
         ST_CHECK: begin
            head_in = phase_ff;
            i_in = '0;
            j_in = '0;
            if (n_ff == 3'd5 && !phase_ff && flags.gt_unit2) begin
               phase_in = 1'b1;
               cand_in = '0;
               ctl.clear_score = 1'b1;
               state_in = ST_GEN;
            end else if ((n_ff == 3'd5 && !phase_ff) ||
                         (phase_ff && flags.lt_2unit2) ||
                         (!phase_ff && flags.lt_unit2)) begin
               state_in = ST_EMIT;
            end else begin
               stat_in = STAT_NOTFOUND;
               state_in = ST_RESULT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               ouser_in = STAT_FOUND;
               if (j_ff == '0) begin
                  odata_in = {2'b00, (head_ff ? 2'b10 : 2'b11), 4'd0};
                  olast_in = 1'b0;
                  i_in = '0;
                  j_in = IW'(1);
                  cand_in = 6'd1;
               end else begin
                  odata_in = {2'b00, prod, cand_ff[3:0]};
                  olast_in = (j_ff == nm1) && (i_ff == j_ff - 1'b1);
                  cand_in = cand_ff + 6'd1;
                  if (i_ff == j_ff - 1'b1) begin
                     i_in = '0;
                     j_in = j_ff + 1'b1;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
                  if ((j_ff == nm1) && (i_ff == j_ff - 1'b1)) state_in = ST_IDLE;
               end
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in = 8'd0;
               ouser_in = stat_ff;
               olast_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovalid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovalid_ff <= ovalid_in;
         phase_ff <= phase_in;
      end
      n_ff <= n_in;
      cand_ff <= cand_in;
      i_ff <= i_in;
      j_ff <= j_in;
      head_ff <= head_in;
      t_ff <= t_in;
      stat_ff <= stat_in;
      odata_ff <= odata_in;
      ouser_ff <= ouser_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = odata_ff;
   assign rsp_tuser = ouser_ff;
   assign rsp_tlast = olast_ff;
endmodule
